@@ src/swing_pivot_detector_top_macros.svh @@
// ============================================================================
// Swing pivot detector assertion macros
// Shared property shapes for the checker; clocked on aclk, held off in reset.
// ============================================================================
`ifndef SWING_PIVOT_DETECTOR_TOP_MACROS_SVH
`define SWING_PIVOT_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication
`define SPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/spd_pkg.sv @@
// ============================================================================
// spd_pkg
// Types and constants shared by the swing pivot detector and its checker.
// ============================================================================
package spd_pkg;

    // Default parameter values
    localparam int MAX_HALF_WINDOW_DEF = 8;
    localparam int PRICE_BITS_DEF      = 32;

    // Fixed field widths
    localparam int CFG_BITS   = 4;
    localparam int BAR_BITS   = 32;
    localparam int INDEX_BITS = 24;
    localparam int PIVOT_BITS = 32;

    localparam logic [CFG_BITS-1:0]   HALF_WINDOW_RST = 4'd3;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX       = {INDEX_BITS{1'b1}};

    // One result beat
    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  is_low;
        logic [PIVOT_BITS-1:0] price;
        logic                  last;
    } result_t;

endpackage

@@ src/swing_pivot_detector_top.sv @@
// ============================================================================
// swing_pivot_detector_top
// Sliding-window swing pivot detector with alternating pending pivot.
// ============================================================================
// One bar is taken per cycle as long as the output queue has room for two
// results. A bar waits in the input register, where the centre of the window
// (half_window bars back) is compared in parallel with all the other bars of
// the window, and the pending pivot is updated. Results (zero, one or two per
// bar) go into a three-entry output queue and are offered on m_ from there.
// The only slowdown is a downstream that takes fewer beats than are produced
// (a bar that releases two pivots puts two beats into the queue).
// half_window is clamped to 1 .. MAX_HALF_WINDOW and should only be written
// while no bar is in flight.
// ============================================================================
module swing_pivot_detector_top #(
    parameter int MAX_HALF_WINDOW = spd_pkg::MAX_HALF_WINDOW_DEF,
    parameter int PRICE_BITS      = spd_pkg::PRICE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [spd_pkg::CFG_BITS-1:0]  cfg_wr_data,
    // bar input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [spd_pkg::BAR_BITS-1:0]  s_bar_high,
    input  logic [spd_pkg::BAR_BITS-1:0]  s_bar_low,
    input  logic                          s_end_of_series,
    // pivot output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [spd_pkg::INDEX_BITS-1:0] m_pivot_index,
    output logic                          m_pivot_is_low,
    output logic [spd_pkg::PIVOT_BITS-1:0] m_pivot_price,
    output logic                          m_run_last
);
    import spd_pkg::*;

    localparam int WIN_DEPTH   = 2 * MAX_HALF_WINDOW + 1;
    localparam int HW_BITS     = $clog2(MAX_HALF_WINDOW + 1);
    localparam int CLAMP_BITS  = (HW_BITS > CFG_BITS) ? HW_BITS : CFG_BITS;
    localparam int POS_BITS    = $clog2(WIN_DEPTH);
    localparam int QUEUE_DEPTH = 3;
    localparam int QCNT_BITS   = 2;

    typedef logic [PRICE_BITS-1:0] price_t;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [CFG_BITS-1:0]   half_window_reg;
    logic                  in_valid_reg;
    price_t                in_high_reg;
    price_t                in_low_reg;
    logic                  in_eos_reg;
    price_t                win_high_reg [WIN_DEPTH-1];
    price_t                win_low_reg  [WIN_DEPTH-1];
    logic [INDEX_BITS-1:0] bar_cnt_reg;
    logic                  pend_valid_reg;
    logic                  pend_low_reg;
    logic [INDEX_BITS-1:0] pend_idx_reg;
    price_t                pend_price_reg;
    result_t               q_reg [QUEUE_DEPTH];
    logic [QCNT_BITS-1:0]  q_cnt_reg;

    logic                  pend_valid_next;
    logic                  pend_low_next;
    logic [INDEX_BITS-1:0] pend_idx_next;
    price_t                pend_price_next;
    result_t               q_next [QUEUE_DEPTH];
    logic [QCNT_BITS-1:0]  q_cnt_next;

    // ------------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------------
    logic [CLAMP_BITS-1:0] hw_ext;
    logic [HW_BITS-1:0]    hw;
    logic [POS_BITS:0]     two_hw;
    price_t                view_high [WIN_DEPTH];
    price_t                view_low  [WIN_DEPTH];
    price_t                ctr_high;
    price_t                ctr_low;
    logic                  is_high;
    logic                  is_low;
    logic                  in_window;
    logic                  pivot;
    logic                  kind_low;
    price_t                piv_price;
    logic [INDEX_BITS-1:0] piv_idx;
    logic                  pop;
    logic [QCNT_BITS-1:0]  cnt_ap;
    logic                  adv;
    logic [QCNT_BITS-1:0]  n_res;
    result_t               res0;
    result_t               res1;
    result_t               shifted [QUEUE_DEPTH];

    // Half window clamp
    always_comb begin
        hw_ext = CLAMP_BITS'(half_window_reg);
        if (hw_ext == '0) begin
            hw_ext = CLAMP_BITS'(1);
        end else if (hw_ext > CLAMP_BITS'(MAX_HALF_WINDOW)) begin
            hw_ext = CLAMP_BITS'(MAX_HALF_WINDOW);
        end
        hw     = HW_BITS'(hw_ext);
        two_hw = (POS_BITS + 1)'(hw) << 1;
    end

    // Window as seen after this bar is shifted in
    always_comb begin
        view_high[0] = in_high_reg;
        view_low[0]  = in_low_reg;
        for (int i = 1; i < WIN_DEPTH; i++) begin
            view_high[i] = win_high_reg[i-1];
            view_low[i]  = win_low_reg[i-1];
        end
    end

    // Centre against every other bar of the window, in parallel
    always_comb begin
        logic active;
        ctr_high = view_high[POS_BITS'(hw)];
        ctr_low  = view_low[POS_BITS'(hw)];
        is_high  = 1'b1;
        is_low   = 1'b1;
        for (int j = 0; j < WIN_DEPTH; j++) begin
            active = ((POS_BITS + 1)'(j) <= two_hw) && (POS_BITS'(j) != POS_BITS'(hw));
            if (active && (view_high[j] >= ctr_high)) begin
                is_high = 1'b0;
            end
            if (active && (view_low[j] <= ctr_low)) begin
                is_low = 1'b0;
            end
        end
        in_window = bar_cnt_reg >= INDEX_BITS'(two_hw);
        pivot     = in_window && (is_high || is_low);
        kind_low  = !is_high;
        piv_price = kind_low ? ctr_low : ctr_high;
        piv_idx   = bar_cnt_reg - INDEX_BITS'(hw);
    end

    // Queue flow
    assign pop     = m_valid && m_ready;
    assign cnt_ap  = q_cnt_reg - QCNT_BITS'(pop);
    assign adv     = in_valid_reg && (cnt_ap <= QCNT_BITS'(1));
    assign s_ready = !in_valid_reg || adv;

    // Pending pivot update and released results
    always_comb begin
        logic better;
        logic rel_old;
        result_t old_res;
        result_t mid_res;
        pend_valid_next = pend_valid_reg;
        pend_low_next   = pend_low_reg;
        pend_idx_next   = pend_idx_reg;
        pend_price_next = pend_price_reg;
        rel_old         = 1'b0;
        better          = kind_low ? (piv_price < pend_price_reg)
                                   : (piv_price > pend_price_reg);
        old_res.index   = pend_idx_reg;
        old_res.is_low  = pend_low_reg;
        old_res.price   = PIVOT_BITS'(pend_price_reg);
        old_res.last    = 1'b0;
        if (pivot) begin
            if (pend_valid_reg && (pend_low_reg == kind_low)) begin
                if (better) begin
                    pend_idx_next   = piv_idx;
                    pend_price_next = piv_price;
                end
            end else begin
                rel_old         = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_low_next   = kind_low;
                pend_idx_next   = piv_idx;
                pend_price_next = piv_price;
            end
        end
        mid_res.index  = pend_idx_next;
        mid_res.is_low = pend_low_next;
        mid_res.price  = PIVOT_BITS'(pend_price_next);
        mid_res.last   = 1'b1;
        res0  = old_res;
        res1  = mid_res;
        n_res = QCNT_BITS'(rel_old);
        if (in_eos_reg && pend_valid_next) begin
            pend_valid_next = 1'b0;
            if (rel_old) begin
                n_res = QCNT_BITS'(2);
            end else begin
                res0  = mid_res;
                n_res = QCNT_BITS'(1);
            end
        end else begin
            res0.last = 1'b1;
        end
    end

    // Output queue: shift on pop, append at the new tail
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (pop && (k < QUEUE_DEPTH - 1)) begin
                shifted[k] = q_reg[k+1];
            end else begin
                shifted[k] = q_reg[k];
            end
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            q_next[k] = shifted[k];
            if (adv && (n_res != '0) && (QCNT_BITS'(k) == cnt_ap)) begin
                q_next[k] = res0;
            end else if (adv && (n_res == QCNT_BITS'(2))
                         && (QCNT_BITS'(k) == cnt_ap + QCNT_BITS'(1))) begin
                q_next[k] = res1;
            end
        end
        q_cnt_next = cnt_ap + (adv ? n_res : '0);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_window_reg <= HALF_WINDOW_RST;
            in_valid_reg    <= 1'b0;
            bar_cnt_reg     <= '0;
            pend_valid_reg  <= 1'b0;
            q_cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                half_window_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                pend_valid_reg <= pend_valid_next;
                if (bar_cnt_reg != INDEX_MAX) begin
                    bar_cnt_reg <= bar_cnt_reg + INDEX_BITS'(1);
                end
            end
            q_cnt_reg <= q_cnt_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_high_reg <= PRICE_BITS'(s_bar_high);
            in_low_reg  <= PRICE_BITS'(s_bar_low);
            in_eos_reg  <= s_end_of_series;
        end
        if (adv) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_high_reg[i] <= view_high[i];
                win_low_reg[i]  <= view_low[i];
            end
            pend_low_reg   <= pend_low_next;
            pend_idx_reg   <= pend_idx_next;
            pend_price_reg <= pend_price_next;
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            q_reg[k] <= q_next[k];
        end
    end

    // Result port
    assign m_valid        = q_cnt_reg != '0;
    assign m_pivot_index  = q_reg[0].index;
    assign m_pivot_is_low = q_reg[0].is_low;
    assign m_pivot_price  = q_reg[0].price;
    assign m_run_last     = q_reg[0].last;

endmodule

@@ src/spd_checker.sv @@
// ============================================================================
// spd_checker
// Port-level checks on the swing pivot detector result stream.
// ============================================================================
`include "swing_pivot_detector_top_macros.svh"

module spd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [spd_pkg::INDEX_BITS-1:0] m_pivot_index,
    input logic                           m_pivot_is_low,
    input logic [spd_pkg::PIVOT_BITS-1:0] m_pivot_price,
    input logic                           m_run_last
);
    import spd_pkg::*;

    // A stalled result beat stays offered
    `SPD_ASSERT_NXT(a_hold_valid, m_valid && !m_ready, m_valid, "result beat dropped while stalled")

    // and keeps its payload
    `SPD_ASSERT_NXT(a_hold_data, m_valid && !m_ready, $stable(m_pivot_index) && $stable(m_pivot_price) && $stable(m_pivot_is_low) && $stable(m_run_last), "stalled result payload changed")

    // The second result of a bar is already queued behind the first
    `SPD_ASSERT_NXT(a_pair_follows, m_valid && m_ready && !m_run_last, m_valid, "second result of a bar missing")

    // A pair is an old pivot then one of the opposite kind; the index may step
    // back when the half window grows between the two
    `SPD_ASSERT_NXT(a_pair_kind, m_valid && m_ready && !m_run_last, m_pivot_is_low != $past(m_pivot_is_low), "result pair out of order")

endmodule

bind swing_pivot_detector_top spd_checker u_spd_checker (.*);

@@ sim/swing_pivot_detector_top_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swing_pivot_detector_top_test
// Self-checking bench for the swing pivot detector. Bars go in on the s_
// channel under random gaps, and pivot beats are taken on the m_ channel under
// random stalls. A local pivot tracker predicts every beat from the accepted
// bars and the half window, and each beat is checked field by field.
// ============================================================================
module swing_pivot_detector_top_test;
    import spd_pkg::*;

    localparam int WIN_SLOTS    = 2 * MAX_HALF_WINDOW_DEF + 1;
    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 300;

    // DUT connections
    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_BITS-1:0]   cfg_wr_data     = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [BAR_BITS-1:0]   s_bar_high      = '0;
    logic [BAR_BITS-1:0]   s_bar_low       = '0;
    logic                  s_end_of_series = 1'b0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [INDEX_BITS-1:0] m_pivot_index;
    logic                  m_pivot_is_low;
    logic [PIVOT_BITS-1:0] m_pivot_price;
    logic                  m_run_last;

    // Pivot tracker state
    logic [BAR_BITS-1:0]   win_high [WIN_SLOTS];
    logic [BAR_BITS-1:0]   win_low  [WIN_SLOTS];
    logic [INDEX_BITS-1:0] next_bar_no;
    logic                  held_valid;
    logic                  held_is_low;
    logic [INDEX_BITS-1:0] held_index;
    logic [PIVOT_BITS-1:0] held_price;
    logic [CFG_BITS-1:0]   half_window_reg;
    result_t               pivot_expect_q [$];

    // Bench control
    int                    fault_count = 0;
    int                    cycle_count = 0;
    int                    sink_hold   = 0;
    bit                    source_gaps = 1'b1;
    bit                    sink_stalls = 1'b1;
    logic [BAR_BITS-1:0]   walk_mid    = 32'h8000_0000;

    swing_pivot_detector_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_bar_high      (s_bar_high),
        .s_bar_low       (s_bar_low),
        .s_end_of_series (s_end_of_series),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pivot_index   (m_pivot_index),
        .m_pivot_is_low  (m_pivot_is_low),
        .m_pivot_price   (m_pivot_price),
        .m_run_last      (m_run_last)
    );

    always #1 aclk = ~aclk;

    // Slide one bar into the window, judge the centre and update the held pivot
    function automatic void track_bar(input logic [BAR_BITS-1:0] hi,
                                      input logic [BAR_BITS-1:0] lo,
                                      input logic eos);
        int                    span;
        int                    centre_no;
        int                    i;
        int                    n;
        logic                  top;
        logic                  bottom;
        logic                  kind_low;
        logic [PIVOT_BITS-1:0] price;
        result_t               outs [2];

        span = int'(half_window_reg);
        if (span < 1) span = 1;
        if (span > MAX_HALF_WINDOW_DEF) span = MAX_HALF_WINDOW_DEF;
        centre_no = int'(next_bar_no);
        n = 0;

        for (i = WIN_SLOTS - 1; i > 0; i--) begin
            win_high[i] = win_high[i-1];
            win_low[i]  = win_low[i-1];
        end
        win_high[0] = hi;
        win_low[0]  = lo;
        if (next_bar_no != INDEX_MAX) next_bar_no++;

        // centre judged only once the window has filled since reset
        if (centre_no >= 2 * span) begin
            top    = 1'b1;
            bottom = 1'b1;
            for (i = 0; i <= 2 * span; i++) begin
                if (i != span) begin
                    if (win_high[i] >= win_high[span]) top = 1'b0;
                    if (win_low[i] <= win_low[span]) bottom = 1'b0;
                end
            end
            if (top || bottom) begin
                // a centre that is both counts as a high
                kind_low = !top;
                price    = kind_low ? win_low[span] : win_high[span];
                if (held_valid && held_is_low == kind_low) begin
                    if (kind_low ? (price < held_price) : (price > held_price)) begin
                        held_index = INDEX_BITS'(centre_no - span);
                        held_price = price;
                    end
                end else begin
                    if (held_valid) begin
                        outs[n] = '{held_index, held_is_low, held_price, 1'b0};
                        n++;
                    end
                    held_valid  = 1'b1;
                    held_is_low = kind_low;
                    held_index  = INDEX_BITS'(centre_no - span);
                    held_price  = price;
                end
            end
        end

        // end of series releases whatever is held, after any swap above
        if (eos && held_valid) begin
            outs[n] = '{held_index, held_is_low, held_price, 1'b0};
            n++;
            held_valid = 1'b0;
        end
        if (n > 0) outs[n-1].last = 1'b1;
        for (i = 0; i < n; i++) pivot_expect_q.push_back(outs[i]);
    endfunction

    function automatic void note_fault(input string what);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Track register writes and accepted bars
    always @(posedge aclk) begin
        if (aresetn && cfg_wr_en) half_window_reg = cfg_wr_data;
        if (aresetn && s_valid && s_ready) track_bar(s_bar_high, s_bar_low, s_end_of_series);
    end

    // Check each accepted pivot beat against the oldest prediction
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pivot_expect_q.size() == 0) begin
                note_fault($sformatf("beat with nothing expected: idx %0d low %0b price %0d",
                                     m_pivot_index, m_pivot_is_low, m_pivot_price));
            end else begin
                want = pivot_expect_q.pop_front();
                if (m_pivot_index !== want.index)
                    note_fault($sformatf("pivot_index exp %0d got %0d",
                                         want.index, m_pivot_index));
                if (m_pivot_is_low !== want.is_low)
                    note_fault($sformatf("pivot_is_low exp %0b got %0b (idx %0d)",
                                         want.is_low, m_pivot_is_low, want.index));
                if (m_pivot_price !== want.price)
                    note_fault($sformatf("pivot_price exp %0d got %0d (idx %0d)",
                                         want.price, m_pivot_price, want.index));
                if (m_run_last !== want.last)
                    note_fault($sformatf("run_last exp %0b got %0b (idx %0d)",
                                         want.last, m_run_last, want.index));
            end
        end
    end

    // Result sink: random stall per beat, plus an occasional long hold-off
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
            end
            stall = sink_stalls ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one bar and hold it until the beat is taken
    task automatic send_bar(input logic [BAR_BITS-1:0] hi, lo, input logic eos);
        int gap;
        gap = source_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_bar_high      <= hi;
        s_bar_low       <= lo;
        s_end_of_series <= eos;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random-walk bar; now and then a jump, a noise bar or a flat bar
    task automatic send_walk_bar(input int eos_odds);
        logic [BAR_BITS-1:0] spread;
        int unsigned         pick;
        logic                eos;
        pick   = $urandom_range(0, 19);
        spread = $urandom_range(0, 4);
        eos    = ($urandom_range(0, eos_odds - 1) == 0);
        if (pick == 0)
            walk_mid = $urandom();
        else
            walk_mid = walk_mid + $urandom_range(0, 16) - 8;
        if (pick == 1)
            send_bar($urandom(), $urandom(), eos);
        else if (pick == 2)
            send_bar(walk_mid, walk_mid, eos);
        else
            send_bar(walk_mid + spread, walk_mid - spread, eos);
    endtask

    // Stop offering, let every predicted beat arrive, then let the pipe drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pivot_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_half_window(input logic [CFG_BITS-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Reset half window: early bars cannot be judged, end with nothing held
    task automatic test_reset_window();
        send_bar(32'd100, 32'd50, 1'b1);
        send_bar(32'd200, 32'd10, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_bar(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_bar(32'd150, 32'd60, 1'b0);
        send_bar(32'd120, 32'd70, 1'b0);
        send_bar(32'd130, 32'd80, 1'b0);
        send_bar(32'd110, 32'd90, 1'b0);
    endtask

    // Narrow window: both-kind centre, replacement, swap, flush order, ties
    task automatic test_directed_pivots();
        write_half_window(4'd1);
        send_bar(32'd10, 32'd5, 1'b0);
        send_bar(32'd20, 32'd1, 1'b0);
        send_bar(32'd15, 32'd8, 1'b0);
        send_bar(32'd30, 32'd12, 1'b0);
        send_bar(32'd25, 32'd20, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'd3, 1'b0);
        send_bar(32'd40, 32'd0, 1'b0);
        send_bar(32'd50, 32'd10, 1'b0);
        send_bar(32'd45, 32'd0, 1'b1);
        send_bar(32'd45, 32'd0, 1'b0);
        send_bar(32'd45, 32'd0, 1'b1);
        send_bar(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_bar(32'd0, 32'hFFFF_FFFE, 1'b0);
        send_bar(32'd0, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Sweep the half window over both ends and the out-of-range codes
    task automatic test_half_window_sweep();
        logic [CFG_BITS-1:0] sweep [6];
        int                  k;
        int                  b;
        sweep = '{4'd8, 4'd0, 4'd15, 4'd2, 4'd9, 4'd3};
        for (k = 0; k < 6; k++) begin
            write_half_window(sweep[k]);
            for (b = 0; b < 30; b++) send_walk_bar(25);
        end
    endtask

    // Random phases; the first runs with no gaps and no stalls at all
    task automatic test_random_series();
        int phase;
        int b;
        for (phase = 0; phase < 8; phase++) begin
            write_half_window(4'($urandom_range(0, 15)));
            source_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
            sink_stalls = (phase != 0) && ($urandom_range(0, 3) != 0);
            for (b = 0; b < 70; b++) send_walk_bar(40);
        end
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Long hold-off on the result side while bars keep coming back to back
    task automatic test_output_backpressure();
        int b;
        write_half_window(4'd1);
        source_gaps = 1'b0;
        sink_hold   = HOLD_CYCLES;
        for (b = 0; b < 60; b++) send_walk_bar(20);
        source_gaps = 1'b1;
    endtask

    initial begin : stimulus
        int i;
        for (i = 0; i < WIN_SLOTS; i++) begin
            win_high[i] = '0;
            win_low[i]  = '0;
        end
        next_bar_no     = '0;
        held_valid      = 1'b0;
        held_is_low     = 1'b0;
        held_index      = '0;
        held_price      = '0;
        half_window_reg = HALF_WINDOW_RST;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_window();
        test_directed_pivots();
        test_half_window_sweep();
        test_output_backpressure();
        test_random_series();
        settle();

        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
